// ===== rtl/pirl_pkg.sv =====
package pirl_pkg;

  // Field widths of one request and one result
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned STAT_W  = 2;

  // Request mode codes
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DUMP   = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

  // Operation broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_ROTATE
  } cell_op_e;

  typedef struct packed {
    cell_op_e            op;
    logic [POS_W-1:0]    pos;       // insert or remove position
    logic [POS_W-1:0]    last_idx;  // index of the last valid entry (rotate)
    logic [VALUE_W-1:0]  value;     // value to insert
  } cell_ctrl_t;

endpackage

// ===== rtl/pirl_cell.sv =====
module pirl_cell #(
  parameter int CellIdx = 0
) (
  input  logic                         clk_i,
  input  pirl_pkg::cell_ctrl_t         ctrl_i,
  input  logic [pirl_pkg::VALUE_W-1:0] left_i,   // neighbor one index below
  input  logic [pirl_pkg::VALUE_W-1:0] right_i,  // neighbor one index above
  input  logic [pirl_pkg::VALUE_W-1:0] head_i,   // entry of cell 0
  output logic [pirl_pkg::VALUE_W-1:0] q_o
);

  localparam logic [pirl_pkg::POS_W-1:0] Idx = pirl_pkg::POS_W'(CellIdx);

  logic [pirl_pkg::VALUE_W-1:0] entry_d, entry_q;

  // Pick the next entry from neighbors, the new value or the head
  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      pirl_pkg::CELL_INSERT: begin
        if (Idx > ctrl_i.pos) begin
          entry_d = left_i;
        end else if (Idx == ctrl_i.pos) begin
          entry_d = ctrl_i.value;
        end
      end
      pirl_pkg::CELL_REMOVE: begin
        if (Idx >= ctrl_i.pos) begin
          entry_d = right_i;
        end
      end
      pirl_pkg::CELL_ROTATE: begin
        if (Idx == ctrl_i.last_idx) begin
          entry_d = head_i;
        end else if (Idx < ctrl_i.last_idx) begin
          entry_d = right_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign q_o = entry_q;

endmodule

// ===== rtl/positional_insert_remove_list.sv =====
// Ordered list of up to CAPACITY signed 32-bit values held in a chain of
// cells, one entry per cell. A request with tuser 0 inserts the value at a
// position from 0 to the count, 1 removes the entry at a position below the
// count, 2 dumps the list, 3 is ignored. An insert or remove gives one result
// (tuser: 0 done, 1 position out of range, 2 list full; tdata zero, tlast
// high); all cells shift in parallel. A dump gives one result per stored entry,
// one per cycle while the output is not stalled, taken from cell 0 while the
// chain rotates by one, so it occupies the block until its last entry is given
// and leaves the list as it was; an empty list dumps nothing. A new request is
// taken only while no dump is running and the output register is free or being
// emptied. Entries hold no reset value; only stored entries are read.
module positional_insert_remove_list #(
  parameter int CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // item_value[31:0], position[38:32], zero pad
  input  logic [1:0]  s_axis_tuser,   // mode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // entry_value[31:0]
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  output logic        m_axis_tlast    // last
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic                          state_d, state_q;
  logic [CntW-1:0]               count_d, count_q;
  logic [CntW-1:0]               rem_d, rem_q;
  logic                          out_valid_d, out_valid_q;
  logic [pirl_pkg::STAT_W-1:0]   out_status_d, out_status_q;
  logic [pirl_pkg::VALUE_W-1:0]  out_value_d, out_value_q;
  logic                          out_last_d, out_last_q;
  logic                          out_load;
  logic                          out_free;
  logic                          accept;
  logic [pirl_pkg::MODE_W-1:0]   in_mode;
  logic [pirl_pkg::VALUE_W-1:0]  in_value;
  logic [pirl_pkg::POS_W-1:0]    in_pos;
  logic [pirl_pkg::POS_W-1:0]    count_ext;
  pirl_pkg::cell_ctrl_t          ctrl;
  logic [pirl_pkg::VALUE_W-1:0]  cell_q [CAPACITY];

  // Unpack the request
  assign in_mode   = s_axis_tuser;
  assign in_value  = s_axis_tdata[31:0];
  assign in_pos    = s_axis_tdata[38:32];
  assign count_ext = pirl_pkg::POS_W'(count_q);

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Decode requests and step dumps
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    rem_d         = rem_q;
    out_load      = 1'b0;
    out_status_d  = pirl_pkg::STATUS_DONE;
    out_value_d   = '0;
    out_last_d    = 1'b1;
    ctrl.op       = pirl_pkg::CELL_HOLD;
    ctrl.pos      = in_pos;
    ctrl.last_idx = count_ext - 1'b1;
    ctrl.value    = in_value;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            pirl_pkg::MODE_INSERT: begin
              out_load = 1'b1;
              if (in_pos > count_ext) begin
                out_status_d = pirl_pkg::STATUS_RANGE;
              end else if (count_q == CntW'(CAPACITY)) begin
                out_status_d = pirl_pkg::STATUS_FULL;
              end else begin
                ctrl.op = pirl_pkg::CELL_INSERT;
                count_d = count_q + 1'b1;
              end
            end
            pirl_pkg::MODE_REMOVE: begin
              out_load = 1'b1;
              if (in_pos >= count_ext) begin
                out_status_d = pirl_pkg::STATUS_RANGE;
              end else begin
                ctrl.op = pirl_pkg::CELL_REMOVE;
                count_d = count_q - 1'b1;
              end
            end
            pirl_pkg::MODE_DUMP: begin
              if (count_q != '0) begin
                state_d = ST_DUMP;
                rem_d   = count_q;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          ctrl.op     = pirl_pkg::CELL_ROTATE;
          out_load    = 1'b1;
          out_value_d = cell_q[0];
          out_last_d  = (rem_q == CntW'(1));
          rem_d       = rem_q - 1'b1;
          if (rem_q == CntW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output register valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status_d;
      out_value_q  <= out_value_d;
      out_last_q   <= out_last_d;
    end
  end

  // Chain of entry cells
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic [pirl_pkg::VALUE_W-1:0] left_w, right_w;
    if (gi == 0) begin : g_first
      assign left_w = cell_q[0];
    end else begin : g_inner_l
      assign left_w = cell_q[gi-1];
    end
    if (gi == CAPACITY - 1) begin : g_end
      assign right_w = cell_q[gi];
    end else begin : g_inner_r
      assign right_w = cell_q[gi+1];
    end
    pirl_cell #(
      .CellIdx(gi)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .left_i (left_w),
      .right_i(right_w),
      .head_i (cell_q[0]),
      .q_o    (cell_q[gi])
    );
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== rtl/pirl_checker.sv =====
module pirl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // Hold a stalled result until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid &&
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // Take no request while a result is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("request taken while output stalled");

  // Report only defined status codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == pirl_pkg::STATUS_DONE) ||
      (m_axis_tuser == pirl_pkg::STATUS_RANGE) || (m_axis_tuser == pirl_pkg::STATUS_FULL))
    else $error("undefined status code");

  // Rejected requests give one zero result marked last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != pirl_pkg::STATUS_DONE) |->
      m_axis_tlast && (m_axis_tdata == '0))
    else $error("rejected request result malformed");

endmodule

bind positional_insert_remove_list pirl_checker u_pirl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

// ===== test/tb_positional_insert_remove_list.sv =====
`timescale 1ns / 1ps

module tb_positional_insert_remove_list;

  localparam int CAPACITY    = 64;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 20;
  localparam int MIXED_ITEMS = 16;
  localparam int BURST_ITEMS = 16;
  localparam int SHRINK_TO   = 56;
  localparam logic [pirl_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

  // One result as seen on the master side
  typedef struct packed {
    logic [pirl_pkg::STAT_W-1:0]  status;
    logic [pirl_pkg::VALUE_W-1:0] value;
    logic                         last;
  } list_result_t;

  // One directed request; status is only used where typed is set
  typedef struct packed {
    logic [pirl_pkg::MODE_W-1:0]  mode;
    logic [pirl_pkg::VALUE_W-1:0] value;
    logic [pirl_pkg::POS_W-1:0]   pos;
    logic                         typed;
    logic [pirl_pkg::STAT_W-1:0]  status;
  } stim_row_t;

  localparam int N_DIRECTED = 22;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // item_value[31:0], position[38:32], zero pad
  logic [1:0]  s_axis_tuser;   // mode[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // entry_value[31:0]
  logic [1:0]  m_axis_tuser;   // status[1:0]
  logic        m_axis_tlast;   // last

  // Shadow copy of the list
  logic [pirl_pkg::VALUE_W-1:0] shadow_entries [CAPACITY];
  int                           shadow_count;

  list_result_t expected_results [$];
  int           err_count;
  int           cycle_cnt;
  bit           no_idle;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{pirl_pkg::MODE_REMOVE, 32'h0000_0000, 7'd0,   1'b1, pirl_pkg::STATUS_RANGE},
    '{pirl_pkg::MODE_DUMP,   32'h0000_0000, 7'd0,   1'b0, pirl_pkg::STATUS_DONE},
    '{pirl_pkg::MODE_INSERT, 32'h7FFF_FFFF, 7'd1,   1'b1, pirl_pkg::STATUS_RANGE},
    '{pirl_pkg::MODE_INSERT, 32'h8000_0000, 7'd0,   1'b1, pirl_pkg::STATUS_DONE},
    '{pirl_pkg::MODE_INSERT, 32'h7FFF_FFFF, 7'd1,   1'b1, pirl_pkg::STATUS_DONE},
    '{pirl_pkg::MODE_INSERT, 32'hFFFF_FFFF, 7'd0,   1'b1, pirl_pkg::STATUS_DONE},
    '{pirl_pkg::MODE_INSERT, 32'h0000_0000, 7'd1,   1'b1, pirl_pkg::STATUS_DONE},
    '{pirl_pkg::MODE_DUMP,   32'hDEAD_BEEF, 7'd127, 1'b0, pirl_pkg::STATUS_DONE},
    '{pirl_pkg::MODE_INSERT, 32'h1234_5678, 7'd127, 1'b1, pirl_pkg::STATUS_RANGE},
    '{pirl_pkg::MODE_REMOVE, 32'h0000_0000, 7'd4,   1'b1, pirl_pkg::STATUS_RANGE},
    '{pirl_pkg::MODE_REMOVE, 32'hFFFF_FFFF, 7'd127, 1'b1, pirl_pkg::STATUS_RANGE},
    '{MODE_UNUSED,           32'hFFFF_FFFF, 7'd0,   1'b0, pirl_pkg::STATUS_DONE},
    '{pirl_pkg::MODE_REMOVE, 32'h0000_0000, 7'd1,   1'b1, pirl_pkg::STATUS_DONE},
    '{pirl_pkg::MODE_DUMP,   32'h0000_0000, 7'd0,   1'b0, pirl_pkg::STATUS_DONE},
    '{pirl_pkg::MODE_REMOVE, 32'h0000_0000, 7'd2,   1'b1, pirl_pkg::STATUS_DONE},
    '{pirl_pkg::MODE_REMOVE, 32'h0000_0000, 7'd0,   1'b1, pirl_pkg::STATUS_DONE},
    '{pirl_pkg::MODE_DUMP,   32'h0000_0000, 7'd0,   1'b0, pirl_pkg::STATUS_DONE},
    '{pirl_pkg::MODE_REMOVE, 32'h0000_0000, 7'd0,   1'b1, pirl_pkg::STATUS_DONE},
    '{pirl_pkg::MODE_DUMP,   32'h0000_0000, 7'd0,   1'b0, pirl_pkg::STATUS_DONE},
    '{pirl_pkg::MODE_INSERT, 32'h5A5A_5A5A, 7'd0,   1'b1, pirl_pkg::STATUS_DONE},
    '{pirl_pkg::MODE_INSERT, 32'hA5A5_A5A5, 7'd1,   1'b1, pirl_pkg::STATUS_DONE},
    '{pirl_pkg::MODE_DUMP,   32'h0000_0000, 7'd0,   1'b0, pirl_pkg::STATUS_DONE}
  };

  positional_insert_remove_list #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 9);
  endfunction

  // Favor the signed extremes now and then
  function automatic logic [pirl_pkg::VALUE_W-1:0] draw_value();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  // Apply an insert or remove to the shadow list and return its status
  function automatic logic [pirl_pkg::STAT_W-1:0] apply_list_edit(
      input logic [pirl_pkg::MODE_W-1:0]  mode,
      input logic [pirl_pkg::VALUE_W-1:0] value,
      input logic [pirl_pkg::POS_W-1:0]   pos);
    int p;
    p = int'(pos);
    if (mode == pirl_pkg::MODE_INSERT) begin
      if (p > shadow_count) return pirl_pkg::STATUS_RANGE;
      if (shadow_count >= CAPACITY) return pirl_pkg::STATUS_FULL;
      for (int i = shadow_count; i > p; i--) shadow_entries[i] = shadow_entries[i-1];
      shadow_entries[p] = value;
      shadow_count++;
      return pirl_pkg::STATUS_DONE;
    end
    if (p >= shadow_count) return pirl_pkg::STATUS_RANGE;
    for (int i = p; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
    shadow_count--;
    return pirl_pkg::STATUS_DONE;
  endfunction

  // Queue the results an accepted request must produce
  function automatic void predict_request(input logic [pirl_pkg::MODE_W-1:0]  mode,
                                          input logic [pirl_pkg::VALUE_W-1:0] value,
                                          input logic [pirl_pkg::POS_W-1:0]   pos,
                                          input logic                         typed,
                                          input logic [pirl_pkg::STAT_W-1:0]  typed_status);
    logic [pirl_pkg::STAT_W-1:0] st;
    case (mode)
      pirl_pkg::MODE_INSERT, pirl_pkg::MODE_REMOVE: begin
        st = apply_list_edit(mode, value, pos);
        expected_results.push_back(list_result_t'{typed ? typed_status : st, '0, 1'b1});
      end
      pirl_pkg::MODE_DUMP: begin
        for (int i = 0; i < shadow_count; i++)
          expected_results.push_back(list_result_t'{pirl_pkg::STATUS_DONE, shadow_entries[i],
                                                    (i == shadow_count - 1)});
      end
      default: ;
    endcase
  endfunction

  // Drive one request and hold it until the handshake
  task automatic send_request(input logic [pirl_pkg::MODE_W-1:0]  mode,
                              input logic [pirl_pkg::VALUE_W-1:0] value,
                              input logic [pirl_pkg::POS_W-1:0]   pos,
                              input logic typed = 1'b0,
                              input logic [pirl_pkg::STAT_W-1:0] typed_status =
                                pirl_pkg::STATUS_DONE);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, pos, value};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_request(mode, value, pos, typed, typed_status);
  endtask

  // Stop sending and wait until every expected result has come
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  // Random mix of edits, dumps and out-of-range noise
  task automatic run_mixed(input int n_items);
    int sent;
    int r;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send_request(pirl_pkg::MODE_INSERT, draw_value(),
                     pirl_pkg::POS_W'($urandom_range(0, shadow_count)));
      end else if (r < 70) begin
        send_request(pirl_pkg::MODE_REMOVE, $urandom(),
                     pirl_pkg::POS_W'(shadow_count > 0 ?
                                      $urandom_range(0, shadow_count - 1) : 0));
      end else if (r < 80) begin
        send_request(pirl_pkg::MODE_DUMP, $urandom(),
                     pirl_pkg::POS_W'($urandom_range(0, 127)));
      end else if (r < 95) begin
        send_request(pirl_pkg::MODE_W'($urandom_range(0, 1)), $urandom(),
                     pirl_pkg::POS_W'($urandom_range(0, 127)));
      end else begin
        // ignored by the block, so it does not count
        send_request(MODE_UNUSED, $urandom(), pirl_pkg::POS_W'($urandom_range(0, 127)));
        sent--;
      end
      sent++;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at %0t: %s got %h expected %h", $time, what, got, want);
    err_count++;
  endtask

  // Compare an accepted result with the oldest expectation
  task automatic check_result();
    list_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result, tdata", m_axis_tdata, '0);
    end else begin
      want = expected_results.pop_front();
      if (m_axis_tuser !== want.status)
        report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
      if (m_axis_tdata !== want.value)
        report_mismatch("entry value", m_axis_tdata, want.value);
      if (m_axis_tlast !== want.last)
        report_mismatch("last", 32'(m_axis_tlast), 32'(want.last));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result();
  end

  // Result side: stall a random number of cycles before each result
  initial begin
    int gap;
    m_axis_tready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Request side
  initial begin
    err_count     = 0;
    shadow_count  = 0;
    no_idle       = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= pirl_pkg::MODE_INSERT;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (directed_rows[i])
      send_request(directed_rows[i].mode, directed_rows[i].value, directed_rows[i].pos,
                   directed_rows[i].typed, directed_rows[i].status);

    run_mixed(MIXED_ITEMS);
    wait_drained();

    // Fill the list, push on the full list, dump it whole, then shrink it by removes
    while (shadow_count < CAPACITY)
      send_request(pirl_pkg::MODE_INSERT, draw_value(),
                   pirl_pkg::POS_W'($urandom_range(0, shadow_count)));
    send_request(pirl_pkg::MODE_INSERT, 32'h7FFF_FFFF, pirl_pkg::POS_W'(CAPACITY));
    send_request(pirl_pkg::MODE_INSERT, 32'h8000_0000, '0);
    send_request(pirl_pkg::MODE_INSERT, 32'h0000_0001, pirl_pkg::POS_W'(CAPACITY + 1));
    send_request(pirl_pkg::MODE_DUMP, '0, '0);
    send_request(pirl_pkg::MODE_REMOVE, '0, pirl_pkg::POS_W'(CAPACITY));
    send_request(pirl_pkg::MODE_REMOVE, '0, pirl_pkg::POS_W'(CAPACITY - 1));
    while (shadow_count > SHRINK_TO)
      send_request(pirl_pkg::MODE_REMOVE, $urandom(),
                   pirl_pkg::POS_W'($urandom_range(0, shadow_count - 1)));
    wait_drained();

    // Back-to-back stretch on both sides
    no_idle = 1'b1;
    run_mixed(BURST_ITEMS);
    send_request(pirl_pkg::MODE_DUMP, '0, '0);
    no_idle = 1'b0;

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pirl_pkg.sv
rtl/pirl_cell.sv
rtl/positional_insert_remove_list.sv
rtl/pirl_checker.sv
test/tb_positional_insert_remove_list.sv
